@@ rtl/trs_pkg.sv @@
// Shared types, constants and series coefficients for the TRS model matrix block.
package trs_pkg;

    // Pipeline: stage 0 takes the item, stage NSTG-1 is the output register.
    localparam int NSTG      = 21;
    localparam int SC_LAST   = 16;
    localparam int MAT_FIRST = 17;
    localparam int C_FIRST   = 6;
    localparam int CELL_SIN  = 4;
    localparam int CELL_COS  = 5;
    localparam int SIN_MUL   = C_FIRST + 2 * CELL_SIN;
    localparam int SCL_STG   = NSTG - 3;
    localparam int POS_STG   = NSTG - 1;

    localparam logic [21:0] DEG45    = 22'd2949120;
    localparam logic [22:0] DEG90    = 23'd5898240;
    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [22:0] RAD_BIAS = 23'd5898240;
    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [14:0] RCP45_20 = 15'd23302;
    localparam logic [24:0] RCP45_30 = 25'd23860930;

    // one Horner step: p' = 1 - round(t2*p) / d, divide done as multiply by recip, shift
    typedef struct packed {
        logic [31:0] recip;
        logic [5:0]  shift;
        logic [6:0]  half;
    } trs_coef_t;

    localparam trs_coef_t SIN_COEF [CELL_SIN] = '{
        '{32'd3817748708, 6'd38, 7'd36},
        '{32'd3272355083, 6'd37, 7'd21},
        '{32'd3435973837, 6'd36, 7'd10},
        '{32'd2863311531, 6'd34, 7'd3}
    };

    localparam trs_coef_t COS_COEF [CELL_COS] = '{
        '{32'd3054198967, 6'd38, 7'd45},
        '{32'd2454267027, 6'd37, 7'd28},
        '{32'd2290649225, 6'd36, 7'd15},
        '{32'd2863311531, 6'd35, 7'd6},
        '{32'd2147483648, 6'd32, 7'd1}
    };

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } trs_in_t;

    typedef struct packed {
        logic signed [31:0] m_r0c0;
        logic signed [31:0] m_r0c1;
        logic signed [31:0] m_r0c2;
        logic signed [31:0] m_r0c3;
        logic signed [31:0] m_r1c0;
        logic signed [31:0] m_r1c1;
        logic signed [31:0] m_r1c2;
        logic signed [31:0] m_r1c3;
        logic signed [31:0] m_r2c0;
        logic signed [31:0] m_r2c1;
        logic signed [31:0] m_r2c2;
        logic signed [31:0] m_r2c3;
    } trs_out_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } trs_side_t;

    typedef struct packed {
        logic signed [17:0] s;
        logic signed [17:0] c;
    } trs_trig_t;

endpackage

@@ rtl/trs_in_if.sv @@
// Input channel: one transform item per transfer.
interface trs_in_if import trs_pkg::*; ();
    logic    valid;
    logic    ready;
    trs_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/trs_out_if.sv @@
// Output channel: one 3x4 matrix per transfer.
interface trs_out_if import trs_pkg::*; ();
    logic     valid;
    logic     ready;
    trs_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/trs_hcell.sv @@
// Horner cell: two pipeline stages of one series step, t2 travels alongside.
module trs_hcell import trs_pkg::*; (
    input  logic        clk,
    input  logic        en_a,
    input  logic        en_b,
    input  trs_coef_t   coef,
    input  logic [29:0] t2_in,
    input  logic [30:0] p_in,
    output logic [29:0] t2_out,
    output logic [30:0] p_out
);

    logic [60:0] mul_reg;
    logic [29:0] t2a_reg;
    logic [29:0] t2b_reg;
    logic [62:0] quo_reg;
    logic [60:0] rsum;
    logic [30:0] rnd;
    logic [30:0] num;
    logic [62:0] qfull;

    assign rsum  = mul_reg + 61'h2000_0000;
    assign rnd   = rsum[60:30];
    assign num   = rnd + {24'd0, coef.half};
    assign qfull = quo_reg >> coef.shift;

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            mul_reg <= {31'd0, t2_in} * {30'd0, p_in};
            t2a_reg <= t2_in;
        end
        if (en_b)
        begin
            quo_reg <= {32'd0, num} * {31'd0, coef.recip};
            t2b_reg <= t2a_reg;
        end
    end

    assign t2_out = t2b_reg;
    assign p_out  = ONE_Q30 - qfull[30:0];

endmodule

@@ rtl/trs_sincos.sv @@
// Sine and cosine of a Q16.16 angle in degrees: reduction, radians, two Horner chains.
module trs_sincos import trs_pkg::*; (
    input  logic               clk,
    input  logic [SC_LAST:0]   en,
    input  logic signed [31:0] ang,
    output trs_trig_t          trig
);

    // stage 0: high part of angle mod 45 via reciprocal
    logic [12:0] h;
    logic [13:0] u;
    logic [13:0] u_reg;
    logic [18:0] low_reg;
    logic [28:0] pm_reg;

    assign h = {~ang[31], ang[30:19]};
    assign u = {1'b0, h} + 14'd44;

    // stage 1: quadrant and octant fold
    logic [7:0]  qm;
    logic [13:0] rm_full;
    logic [7:0]  k;
    logic [1:0]  quad;
    logic [7:0]  rk;
    logic [22:0] r;
    logic        swap;
    logic [22:0] xf;
    logic [21:0] x_reg;
    logic [2:0]  fl_pipe [1:SC_LAST-1];

    assign qm      = pm_reg[27:20];
    assign rm_full = u_reg - ({6'd0, qm} * 14'd45);
    assign k       = {rm_full[5:0], low_reg[18:17]};

    always_comb
    begin
        priority if (k >= 8'd135) quad = 2'd3;
        else if (k >= 8'd90)      quad = 2'd2;
        else if (k >= 8'd45)      quad = 2'd1;
        else                      quad = 2'd0;
    end

    assign rk   = k - ({6'd0, quad} * 8'd45);
    assign r    = {rk[5:0], low_reg[16:0]};
    assign swap = r > {1'b0, DEG45};
    assign xf   = swap ? (DEG90 - r) : r;

    // stages 2..4: t = (x*pi + bias) / (45 * 2^18), split into two narrow divides by 45
    logic [53:0] nrad;
    logic [17:0] vh_reg;
    logic [17:0] vl_reg;
    logic [42:0] qh_prod;
    logic [12:0] qh_reg;
    logic [17:0] vh3_reg;
    logic [17:0] vl3_reg;
    logic [17:0] rh_full;
    logic [23:0] u2;
    logic [48:0] ql_prod;
    logic [29:0] t_reg;

    assign nrad    = ({32'd0, x_reg} * {22'd0, PI_Q30}) + {31'd0, RAD_BIAS};
    assign qh_prod = {25'd0, vh_reg} * {18'd0, RCP45_30};
    assign rh_full = vh3_reg - ({5'd0, qh_reg} * 18'd45);
    assign u2      = {rh_full[5:0], vl3_reg};
    assign ql_prod = {25'd0, u2} * {24'd0, RCP45_30};

    // stage 5: t squared
    logic [59:0] tsq;
    logic [29:0] t2_reg;
    logic [29:0] t_pipe [C_FIRST-1:SIN_MUL-1];

    assign tsq = ({30'd0, t_reg} * {30'd0, t_reg}) + 60'h2000_0000;

    // Horner chains
    logic [29:0] st2 [CELL_SIN+1];
    logic [30:0] sp  [CELL_SIN+1];
    logic [29:0] ct2 [CELL_COS+1];
    logic [30:0] cp  [CELL_COS+1];

    assign st2[0] = t2_reg;
    assign sp[0]  = ONE_Q30;
    assign ct2[0] = t2_reg;
    assign cp[0]  = ONE_Q30;

    for (genvar i = 0; i < CELL_SIN; i++)
    begin : g_sin
        trs_hcell u_cell (
            .clk    (clk),
            .en_a   (en[C_FIRST + 2 * i]),
            .en_b   (en[C_FIRST + 2 * i + 1]),
            .coef   (SIN_COEF[i]),
            .t2_in  (st2[i]),
            .p_in   (sp[i]),
            .t2_out (st2[i + 1]),
            .p_out  (sp[i + 1])
        );
    end

    for (genvar i = 0; i < CELL_COS; i++)
    begin : g_cos
        trs_hcell u_cell (
            .clk    (clk),
            .en_a   (en[C_FIRST + 2 * i]),
            .en_b   (en[C_FIRST + 2 * i + 1]),
            .coef   (COS_COEF[i]),
            .t2_in  (ct2[i]),
            .p_in   (cp[i]),
            .t2_out (ct2[i + 1]),
            .p_out  (cp[i + 1])
        );
    end

    // sine tail: times t, then round back to Q30
    logic [60:0] sprod_reg;
    logic [60:0] srnd;
    logic [30:0] sraw_reg;

    assign srnd = sprod_reg + 61'h2000_0000;

    // stage 16: Q30 to Q16, octant swap, quadrant signs
    logic [31:0] s_sum;
    logic [31:0] c_sum;
    logic [17:0] s0;
    logic [17:0] c0;
    logic signed [17:0] sv;
    logic signed [17:0] cv;
    logic [1:0]  quad_d;
    logic        swap_d;

    assign s_sum  = {1'b0, sraw_reg} + 32'd8192;
    assign c_sum  = {1'b0, cp[CELL_COS]} + 32'd8192;
    assign s0     = {1'b0, s_sum[30:14]};
    assign c0     = {1'b0, c_sum[30:14]};
    assign quad_d = fl_pipe[SC_LAST-1][2:1];
    assign swap_d = fl_pipe[SC_LAST-1][0];
    assign sv     = swap_d ? c0 : s0;
    assign cv     = swap_d ? s0 : c0;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            u_reg   <= u;
            low_reg <= ang[18:0];
            pm_reg  <= {15'd0, u} * {14'd0, RCP45_20};
        end
        if (en[1])
        begin
            x_reg      <= xf[21:0];
            fl_pipe[1] <= {quad, swap};
        end
        for (int j = 2; j < SC_LAST; j++)
        begin
            if (en[j])
                fl_pipe[j] <= fl_pipe[j - 1];
        end
        if (en[2])
        begin
            vh_reg <= nrad[53:36];
            vl_reg <= nrad[35:18];
        end
        if (en[3])
        begin
            qh_reg  <= qh_prod[42:30];
            vh3_reg <= vh_reg;
            vl3_reg <= vl_reg;
        end
        if (en[4])
            t_reg <= {qh_reg[11:0], ql_prod[47:30]};
        if (en[5])
        begin
            t2_reg          <= tsq[59:30];
            t_pipe[C_FIRST-1] <= t_reg;
        end
        for (int j = C_FIRST; j < SIN_MUL; j++)
        begin
            if (en[j])
                t_pipe[j] <= t_pipe[j - 1];
        end
        if (en[SIN_MUL])
            sprod_reg <= {31'd0, t_pipe[SIN_MUL-1]} * {30'd0, sp[CELL_SIN]};
        if (en[SIN_MUL+1])
            sraw_reg <= srnd[60:30];
        if (en[SC_LAST])
        begin
            unique case (quad_d)
                2'd0:
                begin
                    trig.s <= sv;
                    trig.c <= cv;
                end
                2'd1:
                begin
                    trig.s <= cv;
                    trig.c <= -sv;
                end
                2'd2:
                begin
                    trig.s <= -sv;
                    trig.c <= -cv;
                end
                2'd3:
                begin
                    trig.s <= -cv;
                    trig.c <= sv;
                end
                default:
                begin
                    trig.s <= sv;
                    trig.c <= cv;
                end
            endcase
        end
    end

endmodule

@@ rtl/trs_mat.sv @@
// Rotation product Rx*Ry*Rz, column scaling and saturation.
module trs_mat import trs_pkg::*; (
    input  logic                      clk,
    input  logic [NSTG-1:MAT_FIRST]   en,
    input  trs_trig_t                 tx,
    input  trs_trig_t                 ty,
    input  trs_trig_t                 tz,
    input  logic signed [31:0]        scale [3],
    output logic signed [31:0]        m [3][3]
);

    localparam logic signed [55:0] HALF16 = 56'sd32768;
    localparam logic signed [55:0] HALF32 = 56'sd2147483648;

    // stage 17: pairwise products
    logic signed [35:0] sxsy_reg, cxsy_reg, cycz_reg, cysz_reg, cxsz_reg;
    logic signed [35:0] cxcz_reg, sxsz_reg, sxcz_reg, sxcy_reg, cxcy_reg;
    logic signed [17:0] sy_reg, sz_reg, cz_reg;

    // stage 18: rotation entries
    logic signed [55:0] a00, a01, a10, a11, a12, a20, a21, a22;
    logic signed [18:0] rr_reg [3][3];

    assign a00 = 56'(cycz_reg) + HALF16;
    assign a01 = HALF16 - 56'(cysz_reg);
    assign a12 = HALF16 - 56'(sxcy_reg);
    assign a22 = 56'(cxcy_reg) + HALF16;
    assign a10 = 56'(sxsy_reg) * 56'(cz_reg) + (56'(cxsz_reg) <<< 16) + HALF32;
    assign a11 = (56'(cxcz_reg) <<< 16) - 56'(sxsy_reg) * 56'(sz_reg) + HALF32;
    assign a20 = (56'(sxsz_reg) <<< 16) - 56'(cxsy_reg) * 56'(cz_reg) + HALF32;
    assign a21 = 56'(cxsy_reg) * 56'(sz_reg) + (56'(sxcz_reg) <<< 16) + HALF32;

    // stage 19/20: scale, round, saturate
    logic signed [50:0] pr_reg [3][3];
    logic signed [50:0] prr    [3][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                prr[i][j] = pr_reg[i][j] + 51'sd32768;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[MAT_FIRST])
        begin
            sxsy_reg <= 36'(tx.s) * 36'(ty.s);
            cxsy_reg <= 36'(tx.c) * 36'(ty.s);
            cycz_reg <= 36'(ty.c) * 36'(tz.c);
            cysz_reg <= 36'(ty.c) * 36'(tz.s);
            cxsz_reg <= 36'(tx.c) * 36'(tz.s);
            cxcz_reg <= 36'(tx.c) * 36'(tz.c);
            sxsz_reg <= 36'(tx.s) * 36'(tz.s);
            sxcz_reg <= 36'(tx.s) * 36'(tz.c);
            sxcy_reg <= 36'(tx.s) * 36'(ty.c);
            cxcy_reg <= 36'(tx.c) * 36'(ty.c);
            sy_reg   <= ty.s;
            sz_reg   <= tz.s;
            cz_reg   <= tz.c;
        end
        if (en[MAT_FIRST+1])
        begin
            rr_reg[0][0] <= a00[34:16];
            rr_reg[0][1] <= a01[34:16];
            rr_reg[0][2] <= 19'(sy_reg);
            rr_reg[1][0] <= a10[50:32];
            rr_reg[1][1] <= a11[50:32];
            rr_reg[1][2] <= a12[34:16];
            rr_reg[2][0] <= a20[50:32];
            rr_reg[2][1] <= a21[50:32];
            rr_reg[2][2] <= a22[34:16];
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (en[MAT_FIRST+2])
                    pr_reg[i][j] <= 51'(rr_reg[i][j]) * 51'(scale[j]);
                if (en[MAT_FIRST+3])
                begin
                    // in range when bits 50..47 all match the sign
                    if (prr[i][j][50:47] == 4'b0000 || prr[i][j][50:47] == 4'b1111)
                        m[i][j] <= prr[i][j][47:16];
                    else if (prr[i][j][50])
                        m[i][j] <= 32'sh8000_0000;
                    else
                        m[i][j] <= 32'sh7fff_ffff;
                end
            end
        end
    end

endmodule

@@ rtl/trs_model_matrix.sv @@
// Top level: TRS model matrix pipeline with per-stage flow control.
// Takes one item per clock unless the pipeline is full and the output is stalled, and
// returns one 3x4 matrix (M = T*Rx*Ry*Rz*S, Q16.16) per item, in order. The
// pipeline is 21 stages: 17 for the three parallel sine/cosine units (angle reduction,
// degree-to-radian divide by 45, then Horner cells, two stages each, ten on the longest
// chain) and 4 for the rotation products, column scaling and saturation. Each stage
// stalls only when it and every stage after it hold data, so bubbles close up while a
// result waits and input keeps flowing until the whole pipeline is full.
module trs_model_matrix import trs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    trs_in_if.sink     item,
    trs_out_if.source  mat
);

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic [NSTG-1:0] en;
    trs_side_t       dly_reg [NSTG];
    trs_trig_t       trig_x, trig_y, trig_z;
    logic signed [31:0] scl [3];
    logic signed [31:0] m   [3][3];

    for (genvar k = 0; k < NSTG; k++)
    begin : g_en
        assign en[k] = mat.ready || !(&v_reg[NSTG-1:k]);
    end

    assign v_next     = (en & {v_reg[NSTG-2:0], item.valid}) | (~en & v_reg);
    assign item.ready = en[0];
    assign mat.valid  = v_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dly_reg[0].pos_x   <= item.data.pos_x;
            dly_reg[0].pos_y   <= item.data.pos_y;
            dly_reg[0].pos_z   <= item.data.pos_z;
            dly_reg[0].scale_x <= item.data.scale_x;
            dly_reg[0].scale_y <= item.data.scale_y;
            dly_reg[0].scale_z <= item.data.scale_z;
        end
        for (int k = 1; k < NSTG; k++)
        begin
            if (en[k])
                dly_reg[k] <= dly_reg[k - 1];
        end
    end

    trs_sincos u_sc_x (
        .clk  (clk),
        .en   (en[SC_LAST:0]),
        .ang  (item.data.rot_x),
        .trig (trig_x)
    );

    trs_sincos u_sc_y (
        .clk  (clk),
        .en   (en[SC_LAST:0]),
        .ang  (item.data.rot_y),
        .trig (trig_y)
    );

    trs_sincos u_sc_z (
        .clk  (clk),
        .en   (en[SC_LAST:0]),
        .ang  (item.data.rot_z),
        .trig (trig_z)
    );

    assign scl[0] = dly_reg[SCL_STG].scale_x;
    assign scl[1] = dly_reg[SCL_STG].scale_y;
    assign scl[2] = dly_reg[SCL_STG].scale_z;

    trs_mat u_mat (
        .clk   (clk),
        .en    (en[NSTG-1:MAT_FIRST]),
        .tx    (trig_x),
        .ty    (trig_y),
        .tz    (trig_z),
        .scale (scl),
        .m     (m)
    );

    assign mat.data.m_r0c0 = m[0][0];
    assign mat.data.m_r0c1 = m[0][1];
    assign mat.data.m_r0c2 = m[0][2];
    assign mat.data.m_r0c3 = dly_reg[POS_STG].pos_x;
    assign mat.data.m_r1c0 = m[1][0];
    assign mat.data.m_r1c1 = m[1][1];
    assign mat.data.m_r1c2 = m[1][2];
    assign mat.data.m_r1c3 = dly_reg[POS_STG].pos_y;
    assign mat.data.m_r2c0 = m[2][0];
    assign mat.data.m_r2c1 = m[2][1];
    assign mat.data.m_r2c2 = m[2][2];
    assign mat.data.m_r2c3 = dly_reg[POS_STG].pos_z;

`ifndef SYNTHESIS
    // input only blocks when every stage holds an item and the output is stalled
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> ((&v_reg) && !mat.ready))
        else $error("input blocked with a bubble in the pipeline");

    // an input transfer always lands in stage 0
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> v_reg[0])
        else $error("accepted item lost at pipeline entry");

    // after an output transfer with nothing behind it, the output goes empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (mat.valid && mat.ready && !v_reg[NSTG-2]) |=> !mat.valid)
        else $error("result repeated after transfer");
`endif

endmodule
